/* design/uapq_pkg.sv */
// shared constants, codes and structs of the unsorted-array priority queue
package uapq_pkg;

   localparam int DEPTH  = 64;
   localparam int POS_W  = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int DATA_W = 32;

   typedef enum logic [1:0] {
      KIND_INSERT  = 2'd0,
      KIND_EXTRACT = 2'd1,
      KIND_FIND    = 2'd2,
      KIND_MODIFY  = 2'd3
   } uapq_kind_type;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_EMPTY     = 2'd1,
      STATUS_NOT_FOUND = 2'd2,
      STATUS_FULL      = 2'd3
   } uapq_status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_RESULT
   } uapq_state_type;

   // search token handed from cell to cell
   typedef struct packed {
      logic                     active;
      logic                     hit;
      logic [POS_W-1:0]         pos;
      logic signed [DATA_W-1:0] value;
      logic signed [DATA_W-1:0] prio;
   } uapq_tok_type;

   // command broadcast from the controller to every cell
   typedef struct packed {
      logic                     insert;
      logic                     shift;
      logic                     modify;
      logic [CNT_W-1:0]         count;
      logic [POS_W-1:0]         pos;
      logic signed [DATA_W-1:0] key;
      logic signed [DATA_W-1:0] prio;
   } uapq_cmd_type;

endpackage

/* design/uapq_if.sv */
// request and response channel interfaces of the priority queue
interface uapq_req_if import uapq_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [1:0]               kind;
   logic signed [DATA_W-1:0] item_value;
   logic signed [DATA_W-1:0] item_priority;

   modport source (output valid, output kind, output item_value, output item_priority,
                   input ready);
   modport sink (input valid, input kind, input item_value, input item_priority,
                 output ready);
endinterface

interface uapq_rsp_if import uapq_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [1:0]               status;
   logic signed [DATA_W-1:0] out_value;
   logic signed [DATA_W-1:0] out_priority;
   logic [CNT_W-1:0]         entry_count;

   modport source (output valid, output status, output out_value, output out_priority,
                   output entry_count, input ready);
   modport sink (input valid, input status, input out_value, input out_priority,
                 input entry_count, output ready);
endinterface

/* design/uapq_cell.sv */
// one storage cell of the queue: holds a pair, passes the search token on
module uapq_cell import uapq_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic [POS_W-1:0]         cell_index,
   input  uapq_cmd_type             cmd,
   input  uapq_tok_type             tok_left,
   output uapq_tok_type             tok_right,
   input  logic signed [DATA_W-1:0] next_value,
   input  logic signed [DATA_W-1:0] next_priority,
   output logic signed [DATA_W-1:0] cell_value,
   output logic signed [DATA_W-1:0] cell_priority
);

   logic signed [DATA_W-1:0] value_ff, value_in;
   logic signed [DATA_W-1:0] priority_ff, priority_in;
   uapq_tok_type             tok_ff, tok_in;
   logic                     live;
   logic                     prio_write;

   assign live = {1'b0, cell_index} < cmd.count;

   always_comb begin
      tok_in     = tok_left;
      prio_write = 1'b0;
      if (tok_left.active && live) begin
         if (cmd.modify) begin
            // first matching value from the oldest end takes the new priority
            if (!tok_left.hit && (value_ff == cmd.key)) begin
               tok_in.hit = 1'b1;
               tok_in.pos = cell_index;
               prio_write = 1'b1;
            end
         end else if (!tok_left.hit || (priority_ff > tok_left.prio)) begin
            // strict compare keeps the oldest on ties
            tok_in.hit   = 1'b1;
            tok_in.pos   = cell_index;
            tok_in.value = value_ff;
            tok_in.prio  = priority_ff;
         end
      end
   end

   always_comb begin
      value_in    = value_ff;
      priority_in = priority_ff;
      if (cmd.insert && ({1'b0, cell_index} == cmd.count)) begin
         value_in    = cmd.key;
         priority_in = cmd.prio;
      end else if (cmd.shift && (cell_index >= cmd.pos)) begin
         value_in    = next_value;
         priority_in = next_priority;
      end
      if (prio_write) begin
         priority_in = cmd.prio;
      end
   end

   always_ff @(posedge clock) begin
      value_ff    <= value_in;
      priority_ff <= priority_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff <= '0;
      end else begin
         tok_ff <= tok_in;
      end
   end

   assign tok_right     = tok_ff;
   assign cell_value    = value_ff;
   assign cell_priority = priority_ff;

endmodule

/* design/unsorted_array_priority_queue_top.sv */
// top level of the unsorted-array max-priority queue: controller and cell chain
//
// The queue holds up to DEPTH (64) value/priority pairs in insertion order, one pair per
// cell in a row of cells. One word on req is handled at a time. On insert the pair is
// written into the cell at the tail when the result word is handed to the response
// register. Extract-max, find-max and modify-priority send a search token down the row,
// one cell per cycle, on a non-empty queue; on an empty queue they answer without a
// search. Extract closes the gap when its result word is handed over, the removed cell
// and every cell above it taking its upper neighbor's pair at once. Ties in priority go
// to the oldest pair. req.ready is high whenever no word is in progress, even while a
// finished result still waits on rsp. The store needs no clearing after reset: only
// cells below the entry count are ever looked at.
module unsorted_array_priority_queue_top import uapq_pkg::*; (
   input logic     clock,
   input logic     reset,
   uapq_req_if.sink   req,
   uapq_rsp_if.source rsp
);

   // controller state
   uapq_state_type           state_ff, state_in;
   logic [CNT_W-1:0]         count_ff;
   logic                     launch_ff;
   logic                     rsp_valid_ff;

   // word in progress
   uapq_kind_type            op_ff;
   logic signed [DATA_W-1:0] key_ff;
   logic signed [DATA_W-1:0] prio_ff;

   // result waiting for commit
   uapq_status_type          res_status_ff;
   logic signed [DATA_W-1:0] res_value_ff;
   logic signed [DATA_W-1:0] res_priority_ff;
   logic [CNT_W-1:0]         res_count_ff;
   logic                     do_insert_ff;
   logic                     do_shift_ff;
   logic [POS_W-1:0]         pos_ff;

   // response register
   uapq_status_type          rsp_status_ff;
   logic signed [DATA_W-1:0] rsp_value_ff;
   logic signed [DATA_W-1:0] rsp_priority_ff;
   logic [CNT_W-1:0]         rsp_count_ff;

   // control strobes
   logic req_ready;
   logic accept;
   logic needs_scan;
   logic scan_done;
   logic xfer_slot;

   // cell chain
   uapq_cmd_type             cmd;
   uapq_tok_type             tok_chain [DEPTH+1];
   logic signed [DATA_W-1:0] val_chain [DEPTH];
   logic signed [DATA_W-1:0] pri_chain [DEPTH];

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = needs_scan ? ST_SCAN : ST_RESULT;
            end
         end
         ST_SCAN: begin
            if (tok_chain[DEPTH].active) begin
               state_in = ST_RESULT;
            end
         end
         ST_RESULT: begin
            if (xfer_slot) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      req_ready = 1'b0;
      scan_done = 1'b0;
      xfer_slot = 1'b0;
      case (state_ff)
         ST_IDLE:   req_ready = 1'b1;
         ST_SCAN:   scan_done = tok_chain[DEPTH].active;
         ST_RESULT: xfer_slot = !rsp_valid_ff || rsp.ready;
         default:   req_ready = 1'b0;
      endcase
   end

   assign accept     = req.valid && req_ready;
   // searches on a non-empty queue walk the cell row
   assign needs_scan = (req.kind != KIND_INSERT) && (count_ff != '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         launch_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         launch_ff <= accept && needs_scan;
         if (xfer_slot) begin
            count_ff     <= res_count_ff;
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // word capture and result forming
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff        <= uapq_kind_type'(req.kind);
         key_ff       <= req.item_value;
         prio_ff      <= req.item_priority;
         do_insert_ff <= 1'b0;
         do_shift_ff  <= 1'b0;
         res_count_ff <= count_ff;
         if (req.kind == KIND_INSERT) begin
            if (count_ff == CNT_W'(DEPTH)) begin
               // full store drops the pair
               res_status_ff   <= STATUS_FULL;
               res_value_ff    <= '0;
               res_priority_ff <= '0;
            end else begin
               res_status_ff   <= STATUS_OK;
               res_value_ff    <= req.item_value;
               res_priority_ff <= req.item_priority;
               res_count_ff    <= count_ff + CNT_W'(1);
               do_insert_ff    <= 1'b1;
            end
         end else if (req.kind == KIND_MODIFY) begin
            // not-found answer: stays when the queue is empty or no cell matches
            res_status_ff   <= STATUS_NOT_FOUND;
            res_value_ff    <= '0;
            res_priority_ff <= '0;
         end else begin
            // empty queue answer for extract and find
            res_status_ff   <= STATUS_EMPTY;
            res_value_ff    <= '1;
            res_priority_ff <= '1;
         end
      end else if (scan_done) begin
         if (op_ff == KIND_MODIFY) begin
            if (tok_chain[DEPTH].hit) begin
               res_status_ff   <= STATUS_OK;
               res_value_ff    <= key_ff;
               res_priority_ff <= prio_ff;
            end
         end else begin
            res_status_ff   <= STATUS_OK;
            res_value_ff    <= tok_chain[DEPTH].value;
            res_priority_ff <= tok_chain[DEPTH].prio;
            pos_ff          <= tok_chain[DEPTH].pos;
            if (op_ff == KIND_EXTRACT) begin
               res_count_ff <= count_ff - CNT_W'(1);
               do_shift_ff  <= 1'b1;
            end
         end
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (xfer_slot) begin
         rsp_status_ff   <= res_status_ff;
         rsp_value_ff    <= res_value_ff;
         rsp_priority_ff <= res_priority_ff;
         rsp_count_ff    <= res_count_ff;
      end
   end

   assign req.ready        = req_ready;
   assign rsp.valid        = rsp_valid_ff;
   assign rsp.status       = rsp_status_ff;
   assign rsp.out_value    = rsp_value_ff;
   assign rsp.out_priority = rsp_priority_ff;
   assign rsp.entry_count  = rsp_count_ff;

   // broadcast command: insert/extract write the store at commit, modify in the search
   always_comb begin
      cmd.insert = xfer_slot && do_insert_ff;
      cmd.shift  = xfer_slot && do_shift_ff;
      cmd.modify = (op_ff == KIND_MODIFY);
      cmd.count  = count_ff;
      cmd.pos    = pos_ff;
      cmd.key    = key_ff;
      cmd.prio   = prio_ff;
   end

   // fresh token enters the first cell in the cycle after the word is taken
   always_comb begin
      tok_chain[0]        = '0;
      tok_chain[0].active = launch_ff;
   end

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic signed [DATA_W-1:0] up_value;
      logic signed [DATA_W-1:0] up_priority;

      // top cell has no upper neighbor: whatever it takes lies past the count
      if (i == DEPTH - 1) begin : g_top
         assign up_value    = key_ff;
         assign up_priority = prio_ff;
      end else begin : g_mid
         assign up_value    = val_chain[i+1];
         assign up_priority = pri_chain[i+1];
      end

      uapq_cell u_cell (
         .clock         (clock),
         .reset         (reset),
         .cell_index    (POS_W'(i)),
         .cmd           (cmd),
         .tok_left      (tok_chain[i]),
         .tok_right     (tok_chain[i+1]),
         .next_value    (up_value),
         .next_priority (up_priority),
         .cell_value    (val_chain[i]),
         .cell_priority (pri_chain[i])
      );
   end

   // entry count never goes past the store size
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("entry count beyond store size");

   // a search is only launched on a non-empty queue
   a_launch_nonempty: assert property (@(posedge clock) disable iff (reset)
      launch_ff |-> (count_ff != '0) && (state_ff == ST_SCAN))
      else $error("search launched without entries");

   // no token reaches the end of the row unless a search is running
   a_token_scan_only: assert property (@(posedge clock) disable iff (reset)
      tok_chain[DEPTH].active |-> (state_ff == ST_SCAN))
      else $error("stray search token");

   // extract commit removes exactly one entry
   a_extract_count: assert property (@(posedge clock) disable iff (reset)
      (xfer_slot && do_shift_ff) |=> (count_ff == $past(count_ff) - CNT_W'(1)))
      else $error("extract did not remove one entry");

endmodule

/* tb/unsorted_array_priority_queue_top_test.sv */
// self-checking testbench of the unsorted-array max-priority queue top level
`timescale 1ns / 100ps

module unsorted_array_priority_queue_top_test import uapq_pkg::*; ();

   // one result word as the queue should report it
   typedef struct {
      uapq_status_type          status;
      logic signed [DATA_W-1:0] value;
      logic signed [DATA_W-1:0] prio;
      logic [CNT_W-1:0]         count;
   } queue_result_type;

   // operation mixes for the random traffic
   localparam int MIX_FILL     = 0;
   localparam int MIX_DRAIN    = 1;
   localparam int MIX_BALANCED = 2;
   localparam int MIX_SEARCH   = 3;

   logic clock;
   logic reset;

   uapq_req_if req ();
   uapq_rsp_if rsp ();

   unsorted_array_priority_queue_top dut (
      .clock (clock),
      .reset (reset),
      .req   (req),
      .rsp   (rsp)
   );

   // shadow copy of the pair store, oldest pair at index 0
   logic signed [DATA_W-1:0] held_values[$];
   logic signed [DATA_W-1:0] held_prios[$];

   // result words predicted for accepted requests, oldest first
   queue_result_type pending_results[$];
   queue_result_type want_result;

   int mismatch_count = 0;
   int rsp_stall_left = 0;

   // idle switches for the request and response sides
   bit send_idle = 1'b1;
   bit recv_idle = 1'b1;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // applies one operation to the shadow store and returns the word it should produce
   function automatic queue_result_type predict_queue_op(uapq_kind_type kind,
                                                         logic signed [DATA_W-1:0] v,
                                                         logic signed [DATA_W-1:0] p);
      queue_result_type r;
      int best;
      r.status = STATUS_OK;
      r.value  = '0;
      r.prio   = '0;
      case (kind)
         KIND_INSERT: begin
            // a full store drops the pair and answers with zeros
            if (held_values.size() >= DEPTH) begin
               r.status = STATUS_FULL;
            end else begin
               held_values.push_back(v);
               held_prios.push_back(p);
               r.value = v;
               r.prio  = p;
            end
         end
         KIND_EXTRACT, KIND_FIND: begin
            if (held_values.size() == 0) begin
               // empty queue answers with all ones
               r.status = STATUS_EMPTY;
               r.value  = '1;
               r.prio   = '1;
            end else begin
               // strict compare keeps the oldest pair among equal priorities
               best = 0;
               for (int i = 1; i < held_prios.size(); i++)
                  if (held_prios[i] > held_prios[best]) best = i;
               r.value = held_values[best];
               r.prio  = held_prios[best];
               if (kind == KIND_EXTRACT) begin
                  held_values.delete(best);
                  held_prios.delete(best);
               end
            end
         end
         default: begin
            // modify: first match from the oldest end gets the new priority
            r.status = STATUS_NOT_FOUND;
            foreach (held_values[i]) begin
               if (r.status == STATUS_NOT_FOUND && held_values[i] == v) begin
                  held_prios[i] = p;
                  r.status      = STATUS_OK;
                  r.value       = v;
                  r.prio        = p;
               end
            end
         end
      endcase
      r.count = CNT_W'(held_values.size());
      return r;
   endfunction

   // random 32-bit word, weighted toward extremes and a small pool for ties and duplicates
   function automatic logic signed [DATA_W-1:0] draw_word();
      logic signed [DATA_W-1:0] w;
      case ($urandom_range(0, 9))
         0:       w = 32'sh7FFF_FFFF;
         1:       w = 32'sh8000_0000;
         2:       w = -32'sd1;
         3:       w = '0;
         4, 5:    w = $signed($urandom_range(0, 7)) - 3;
         default: w = $urandom;
      endcase
      return w;
   endfunction

   // modify key: mostly a value held in the store so matches are common
   function automatic logic signed [DATA_W-1:0] modify_key();
      if (held_values.size() != 0 && $urandom_range(0, 3) != 0)
         return held_values[$urandom_range(0, held_values.size() - 1)];
      return draw_word();
   endfunction

   function automatic uapq_kind_type pick_kind(int mix);
      int r;
      int ins_lim;
      int ext_lim;
      int find_lim;
      r = $urandom_range(0, 99);
      case (mix)
         MIX_FILL:  begin ins_lim = 75; ext_lim = 85; find_lim = 92; end
         MIX_DRAIN: begin ins_lim = 20; ext_lim = 80; find_lim = 90; end
         MIX_SEARCH: begin ins_lim = 25; ext_lim = 40; find_lim = 70; end
         default:   begin ins_lim = 40; ext_lim = 65; find_lim = 80; end
      endcase
      if (r < ins_lim) return KIND_INSERT;
      if (r < ext_lim) return KIND_EXTRACT;
      if (r < find_lim) return KIND_FIND;
      return KIND_MODIFY;
   endfunction

   // drives one request word, waits for the handshake and records its prediction
   task automatic send_word(uapq_kind_type kind, logic signed [DATA_W-1:0] v,
                            logic signed [DATA_W-1:0] p);
      int gap;
      gap = send_idle ? $urandom_range(0, 17) : 0;
      if (gap != 0) begin
         req.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req.valid         <= 1'b1;
      req.kind          <= kind;
      req.item_value    <= v;
      req.item_priority <= p;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      pending_results.push_back(predict_queue_op(kind, v, p));
   endtask

   // drops valid, then waits until every accepted word has been answered
   task automatic drain_results();
      req.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   // every search and modify on an empty queue
   task automatic test_empty_queue();
      send_word(KIND_EXTRACT, 32'sd0, 32'sd0);
      send_word(KIND_FIND, 32'sd0, 32'sd0);
      send_word(KIND_MODIFY, 32'sd5, 32'sd5);
   endtask

   // field extremes, priority ties, duplicate values and misses
   task automatic test_directed_cases();
      send_word(KIND_INSERT, 32'sh7FFF_FFFF, 32'sh8000_0000);
      send_word(KIND_INSERT, 32'sh8000_0000, 32'sh7FFF_FFFF);
      send_word(KIND_INSERT, -32'sd1, -32'sd1);
      // ties the second pair, which is older and must win
      send_word(KIND_INSERT, 32'sd0, 32'sh7FFF_FFFF);
      send_word(KIND_FIND, 32'sd0, 32'sd0);
      send_word(KIND_MODIFY, -32'sd1, 32'sh7FFF_FFFF);
      send_word(KIND_FIND, 32'sd0, 32'sd0);
      // duplicate value: only the oldest copy is modified
      send_word(KIND_INSERT, -32'sd1, 32'sd5);
      send_word(KIND_MODIFY, -32'sd1, 32'sh8000_0000);
      send_word(KIND_MODIFY, 32'sd12345, 32'sd1);
      send_word(KIND_EXTRACT, 32'sd0, 32'sd0);
      send_word(KIND_EXTRACT, 32'sd0, 32'sd0);
      send_word(KIND_FIND, 32'sd0, 32'sd0);
      send_word(KIND_EXTRACT, 32'sd0, 32'sd0);
      send_word(KIND_EXTRACT, 32'sd0, 32'sd0);
      send_word(KIND_EXTRACT, 32'sd0, 32'sd0);
      send_word(KIND_EXTRACT, 32'sd0, 32'sd0);
      // alternating bit patterns
      send_word(KIND_INSERT, 32'sh5555_5555, 32'shAAAA_AAAA);
      send_word(KIND_INSERT, 32'shAAAA_AAAA, 32'sh5555_5555);
      send_word(KIND_FIND, 32'sd0, 32'sd0);
      send_word(KIND_EXTRACT, 32'sd0, 32'sd0);
      send_word(KIND_EXTRACT, 32'sd0, 32'sd0);
   endtask

   // fill to capacity, overflow, then drain back to empty without idling
   task automatic test_full_store();
      while (held_values.size() < DEPTH) send_word(KIND_INSERT, draw_word(), draw_word());
      repeat (3) send_word(KIND_INSERT, draw_word(), draw_word());
      send_word(KIND_MODIFY, modify_key(), draw_word());
      send_word(KIND_FIND, draw_word(), draw_word());
      send_idle = 1'b0;
      recv_idle = 1'b0;
      while (held_values.size() != 0) send_word(KIND_EXTRACT, draw_word(), draw_word());
      send_word(KIND_EXTRACT, draw_word(), draw_word());
      send_word(KIND_FIND, draw_word(), draw_word());
      send_idle = 1'b1;
      recv_idle = 1'b1;
   endtask

   // short bursts with the sender holding off until all results are back
   task automatic test_pause_until_drained();
      uapq_kind_type kind;
      repeat (6) begin
         repeat ($urandom_range(1, 6)) begin
            kind = pick_kind(MIX_BALANCED);
            send_word(kind, (kind == KIND_MODIFY) ? modify_key() : draw_word(), draw_word());
         end
         drain_results();
      end
   endtask

   // mixed traffic in phases that fill, drain, balance or search, with idling varied
   task automatic test_random_traffic(int n_words);
      int mix;
      uapq_kind_type kind;
      mix = MIX_BALANCED;
      for (int n = 0; n < n_words; n++) begin
         if (n % 60 == 0) begin
            mix       = $urandom_range(MIX_FILL, MIX_SEARCH);
            send_idle = ($urandom_range(0, 2) != 0);
            recv_idle = ($urandom_range(0, 2) != 0);
         end
         kind = pick_kind(mix);
         send_word(kind, (kind == KIND_MODIFY) ? modify_key() : draw_word(), draw_word());
      end
      send_idle = 1'b1;
      recv_idle = 1'b1;
   endtask

   // response side: random stalls on ready, each accepted word checked against the oldest
   // prediction
   always @(posedge clock) begin
      if (reset) begin
         rsp.ready      <= 1'b0;
         rsp_stall_left = 0;
      end else begin
         if (rsp.valid && rsp.ready) begin
            if (pending_results.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("%0t: extra word: status %0d value %0d prio %0d count %0d",
                           $time, rsp.status, rsp.out_value, rsp.out_priority,
                           rsp.entry_count);
            end else begin
               want_result = pending_results.pop_front();
               if (rsp.status !== want_result.status || rsp.out_value !== want_result.value ||
                   rsp.out_priority !== want_result.prio ||
                   rsp.entry_count !== want_result.count) begin
                  mismatch_count++;
                  if (mismatch_count <= 10) begin
                     $display("%0t: expected status %0d value %0d prio %0d count %0d",
                              $time, want_result.status, want_result.value, want_result.prio,
                              want_result.count);
                     $display("%0t:      got status %0d value %0d prio %0d count %0d",
                              $time, rsp.status, rsp.out_value, rsp.out_priority,
                              rsp.entry_count);
                  end
               end
            end
            // stall before taking the next word
            rsp_stall_left = recv_idle ? $urandom_range(0, 17) : 0;
            rsp.ready <= (rsp_stall_left == 0);
         end else if (!rsp.ready) begin
            if (rsp_stall_left <= 1) begin
               rsp.ready      <= 1'b1;
               rsp_stall_left = 0;
            end else begin
               rsp_stall_left--;
            end
         end
      end
   end

   initial begin
      reset             <= 1'b1;
      req.valid         <= 1'b0;
      req.kind          <= KIND_INSERT;
      req.item_value    <= '0;
      req.item_priority <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      test_empty_queue();
      test_directed_cases();
      test_full_store();
      test_pause_until_drained();
      test_random_traffic(1700);

      drain_results();
      // watch for stray words as long as a search could still be running
      repeat (DEPTH + 8) @(posedge clock);
      if (mismatch_count == 0 && pending_results.size() == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

   // watchdog well beyond the slowest legal run
   initial begin
      #2_000_000;
      $display("Test completed with failures");
      $finish;
   end

endmodule

/* files.f */
design/uapq_pkg.sv
design/uapq_if.sv
design/uapq_cell.sv
design/unsorted_array_priority_queue_top.sv
tb/unsorted_array_priority_queue_top_test.sv
